### design/psct_pkg.sv
// Package for the per-source cooldown table.
// Holds table sizing, field widths, opcodes and the controller/datapath interface types.
// No dependencies.
package psct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam int KEY_W = 32;
  localparam int TIME_W = 63;
  localparam int REM_W = 40;
  localparam int CD_W = 20;

  localparam logic [CD_W-1:0] US_PER_SECOND = CD_W'(1000000);
  localparam logic [CD_W-1:0] COOLDOWN_RESET = CD_W'(900);
  localparam logic [REM_W-1:0] COOLDOWN_US_RESET = REM_W'(900 * 1000000);

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_COMMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic eval;
    logic result;
  } psct_cmd_t;

  typedef struct packed {
    logic last_addr;
  } psct_stat_t;

endpackage

### design/psct_ctrl.sv
// Controller state machine for the per-source cooldown table.
// Sequences load, table scan, evaluation and result; depends on psct_pkg.
module psct_ctrl
  import psct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output psct_cmd_t  cmd,
  input  psct_stat_t stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        cmd.result = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.result;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### design/psct_dp.sv
// Datapath for the per-source cooldown table: cooldown register, key and time memories,
// used bits, scan trackers, elapsed-time evaluation and result registers.
// Depends on psct_pkg.
module psct_dp
  import psct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CD_W-1:0]   cfg_data,
  input  logic              opcode,
  input  logic              key_present,
  input  logic [KEY_W-1:0]  source_key,
  input  logic [TIME_W-1:0] now_time,
  input  psct_cmd_t         cmd,
  output psct_stat_t        stat,
  output logic              allowed,
  output logic [REM_W-1:0]  remaining_time
);

  logic [CD_W-1:0] cooldown;
  logic [REM_W-1:0] window_us;

  logic item_op;
  logic item_present;
  logic [KEY_W-1:0] item_key;
  logic [TIME_W-1:0] item_now;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used;

  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] cmp_idx;
  logic cmp_vld;
  logic [KEY_W-1:0] rd_key;
  logic [TIME_W-1:0] rd_time;

  logic match_found;
  logic [IDX_W-1:0] match_idx;
  logic [TIME_W-1:0] match_time;
  logic empty_found;
  logic [IDX_W-1:0] empty_idx;
  logic seen;
  logic [IDX_W-1:0] oldest_idx;
  logic [TIME_W-1:0] oldest_time;

  logic active;
  logic refuse;
  logic [REM_W-1:0] diff;
  logic [TIME_W:0] sub_full;
  logic in_cooldown;
  logic entry_used;
  logic hit;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown <= COOLDOWN_RESET;
      window_us <= COOLDOWN_US_RESET;
    end else begin
      if (cfg_write) begin
        cooldown <= cfg_data;
      end
      window_us <= REM_W'(cooldown) * REM_W'(US_PER_SECOND);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op <= opcode;
      item_present <= key_present;
      item_key <= source_key;
      item_now <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= item_key;
      time_mem[wr_idx] <= item_now;
    end
    if (cmd.scan_rd) begin
      rd_key <= key_mem[addr];
      rd_time <= time_mem[addr];
    end
  end

  assign stat.last_addr = (addr == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.scan_rd) begin
        addr <= addr + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= addr;
  end

  assign entry_used = used[cmp_idx];
  assign hit = entry_used && (rd_key == item_key);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
      seen <= 1'b0;
    end else if (cmp_vld) begin
      if (hit && !match_found) begin
        match_found <= 1'b1;
        match_idx <= cmp_idx;
        match_time <= rd_time;
      end
      if (!entry_used && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx <= cmp_idx;
      end
      if (entry_used && (!seen || (rd_time < oldest_time))) begin
        seen <= 1'b1;
        oldest_idx <= cmp_idx;
        oldest_time <= rd_time;
      end
    end
  end

  assign active = (window_us != '0) && item_present;
  assign sub_full = {1'b0, item_now} - {1'b0, match_time};
  assign in_cooldown = !sub_full[TIME_W]
                       && (sub_full[TIME_W-1:REM_W] == '0)
                       && (sub_full[REM_W-1:0] < window_us);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      diff <= sub_full[REM_W-1:0];
      refuse <= active && (item_op == OP_CHECK) && match_found && in_cooldown;
    end
  end

  assign wr_en = cmd.result && active && (item_op == OP_COMMIT);
  assign wr_idx = match_found ? match_idx : (empty_found ? empty_idx : oldest_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      allowed <= !refuse;
      remaining_time <= refuse ? (window_us - diff) : '0;
    end
  end

endmodule

### design/per_source_cooldown_table.sv
// Per-source cooldown table: each word runs through a scan that reads one table entry per
// cycle from the key and time memories, followed by drain, evaluation and result cycles.
// busy is high from the scan through the result state and low while the result is shown,
// so the next word can be accepted at the edge that ends the result cycle. The result word
// is shown for one cycle with done high and cannot be held off by the receiver. Depends on
// psct_pkg, psct_ctrl and psct_dp.
module per_source_cooldown_table
  import psct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CD_W-1:0]   cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic              key_present,
  input  logic [KEY_W-1:0]  source_key,
  input  logic [TIME_W-1:0] now_time,
  output logic              done,
  output logic              allowed,
  output logic [REM_W-1:0]  remaining_time
);

  psct_cmd_t cmd;
  psct_stat_t stat;

  psct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  psct_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .key_present    (key_present),
    .source_key     (source_key),
    .now_time       (now_time),
    .cmd            (cmd),
    .stat           (stat),
    .allowed        (allowed),
    .remaining_time (remaining_time)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for per_source_cooldown_table: directed table walk, then random check/commit words.
// Results are predicted by an in-bench model of the source table. Depends on psct_pkg and per_source_cooldown_table.
module tb
  import psct_pkg::*;
();

  localparam logic [TIME_W-1:0] MAX_T = {TIME_W{1'b1}};
  localparam logic [REM_W-1:0] CD900 = 40'd900000000;
  localparam logic [REM_W-1:0] CD_MAX = 40'd1048575000000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_SIZE = 80;

  typedef struct packed {
    logic              is_cfg;
    logic [CD_W-1:0]   cfg;
    logic              op;
    logic              present;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              typed;
    logic              allowed;
    logic [REM_W-1:0]  rem;
  } stim_t;

  typedef struct packed {
    logic             allowed;
    logic [REM_W-1:0] remaining;
  } verdict_t;

  localparam stim_t PLAN [26] = '{
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd0, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b1, 32'h0, 63'd1000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd1000, 1'b1, 1'b0, CD900},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd900000999, 1'b1, 1'b0, 40'd1},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd900001000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd999, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b0, 32'h0, 63'd5000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd1000, 1'b1, 1'b0, CD900},
    '{1'b0, 20'd0, OP_CHECK, 1'b0, 32'h0, 63'd1000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b1, 32'hFFFFFFFF, MAX_T, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'hFFFFFFFF, MAX_T, 1'b1, 1'b0, CD900},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h12345678, MAX_T, 1'b1, 1'b1, 40'd0},
    '{1'b1, 20'd0, OP_CHECK, 1'b0, 32'h0, 63'd0, 1'b0, 1'b0, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b1, 32'h0, 63'd2000000000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd1000, 1'b1, 1'b1, 40'd0},
    '{1'b1, 20'hFFFFF, OP_CHECK, 1'b0, 32'h0, 63'd0, 1'b0, 1'b0, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd1000, 1'b1, 1'b0, CD_MAX},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'hFFFFFFFF, 63'd0, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b1, 32'h0, 63'd0, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, MAX_T, 1'b1, 1'b1, 40'd0},
    '{1'b1, 20'd1, OP_CHECK, 1'b0, 32'h0, 63'd0, 1'b0, 1'b0, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd999999, 1'b1, 1'b0, 40'd1},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'h0, 63'd1000000, 1'b1, 1'b1, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'hFFFFFFFF, 63'd123456, 1'b0, 1'b0, 40'd0},
    '{1'b0, 20'd0, OP_COMMIT, 1'b1, 32'hA5A5A5A5, 63'd40, 1'b0, 1'b0, 40'd0},
    '{1'b0, 20'd0, OP_CHECK, 1'b1, 32'hA5A5A5A5, 63'd500040, 1'b0, 1'b0, 40'd0}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CD_W-1:0]   cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic              opcode = OP_CHECK;
  logic              key_present = 1'b0;
  logic [KEY_W-1:0]  source_key = '0;
  logic [TIME_W-1:0] now_time = '0;
  logic              done;
  logic              allowed;
  logic [REM_W-1:0]  remaining_time;

  logic [CD_W-1:0]   cooldown_sec = COOLDOWN_RESET;
  logic              slot_used [TABLE_ENTRIES];
  logic [KEY_W-1:0]  slot_key [TABLE_ENTRIES];
  logic [63:0]       slot_stamp [TABLE_ENTRIES];
  verdict_t          verdict_q [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  logic              gaps_on = 1'b1;

  per_source_cooldown_table dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .key_present(key_present),
    .source_key(source_key),
    .now_time(now_time),
    .done(done),
    .allowed(allowed),
    .remaining_time(remaining_time)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic verdict_t cooldown_verdict(logic op, logic present,
                                                logic [KEY_W-1:0] key,
                                                logic [TIME_W-1:0] now);
    verdict_t v;
    logic [63:0] window;
    logic [63:0] elapsed;
    int hit;
    int empty;
    int oldest;
    logic seen;
    v.allowed = 1'b1;
    v.remaining = '0;
    window = 64'(cooldown_sec) * 64'd1000000;
    if (window != 0 && present) begin
      hit = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      if (op == OP_CHECK) begin
        if (hit >= 0 && {1'b0, now} >= slot_stamp[hit]) begin
          elapsed = {1'b0, now} - slot_stamp[hit];
          if (elapsed < window) begin
            v.allowed = 1'b0;
            v.remaining = REM_W'(window - elapsed);
          end
        end
      end else begin
        if (hit < 0) begin
          empty = -1;
          oldest = 0;
          seen = 1'b0;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!slot_used[i]) begin
              if (empty < 0) empty = i;
            end else if (!seen || slot_stamp[i] < slot_stamp[oldest]) begin
              oldest = i;
              seen = 1'b1;
            end
          end
          hit = (empty >= 0) ? empty : oldest;
          slot_used[hit] = 1'b1;
          slot_key[hit] = key;
        end
        slot_stamp[hit] = {1'b0, now};
      end
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  task automatic send_word(input stim_t w);
    int gap;
    verdict_t v;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= w.op;
    key_present <= w.present;
    source_key <= w.key;
    now_time <= w.now;
    do @(posedge clk); while (busy);
    v = cooldown_verdict(w.op, w.present, w.key, w.now);
    if (w.typed) begin
      v.allowed = w.allowed;
      v.remaining = w.rem;
    end
    verdict_q.push_back(v);
  endtask

  task automatic write_cooldown(input logic [CD_W-1:0] value);
    start <= 1'b0;
    while (verdict_q.size() != 0 || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cooldown_sec = value;
    cfg_write <= 1'b0;
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (verdict_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result word allowed=%0b remaining=%0d",
                               allowed, remaining_time));
      end else begin
        want = verdict_q.pop_front();
        if (allowed !== want.allowed || remaining_time !== want.remaining)
          log_mismatch($sformatf("expected allowed=%0b remaining=%0d, got allowed=%0b remaining=%0d",
                                 want.allowed, want.remaining, allowed, remaining_time));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done === 1'b1 || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_t w;
    logic [63:0] clock_now;
    logic [63:0] scale;
    logic [63:0] fill_t;
    logic [KEY_W-1:0] pool [POOL_SIZE];
    int r;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) write_cooldown(PLAN[i].cfg);
      else send_word(PLAN[i]);
    end

    // Bring every live entry to one time, then overflow the table so ties pick the lowest slot.
    write_cooldown(20'd2);
    fill_t = 64'd5000000;
    w = '0;
    w.op = OP_COMMIT;
    w.present = 1'b1;
    w.now = fill_t[TIME_W-1:0];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        w.key = slot_key[i];
        send_word(w);
      end
    end
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      w.key = 32'h0A000000 + i;
      send_word(w);
    end
    w.op = OP_CHECK;
    w.now = fill_t[TIME_W-1:0] + 1;
    for (int i = 0; i < 4; i++) begin
      w.key = 32'h0A000000 + i;
      send_word(w);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_cooldown(20'd1);
        1: write_cooldown(20'hFFFFF);
        2: write_cooldown(20'd0);
        3: write_cooldown(20'd3);
        4: write_cooldown(CD_W'($urandom_range(1, 1000000)));
        5: write_cooldown(COOLDOWN_RESET);
        6: write_cooldown(20'd2);
        default: write_cooldown(20'd1000000);
      endcase
      gaps_on = (ph % 3 != 0);
      clock_now = (ph % 2 == 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000));
      scale = 64'(cooldown_sec) * 64'd1000000;
      if (scale == 0) scale = 64'd1000000;
      foreach (pool[j]) pool[j] = $urandom;
      for (int n = 0; n < 90; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
        end else if (r < 20) begin
          clock_now = clock_now - ({$urandom, $urandom} % (scale / 2 + 1));
        end else begin
          clock_now = clock_now + ({$urandom, $urandom} % (scale / 4 + 1));
        end
        w = '0;
        w.op = 1'($urandom_range(0, 1));
        w.now = ($urandom_range(0, 99) < 5) ? TIME_W'({$urandom, $urandom})
                                             : clock_now[TIME_W-1:0];
        r = $urandom_range(0, 99);
        w.present = (r >= 8);
        if (r < 20) w.key = $urandom;
        else if (r < 65) w.key = pool[$urandom_range(0, 11)];
        else w.key = pool[$urandom_range(0, POOL_SIZE - 1)];
        send_word(w);
      end
    end

    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
design/psct_pkg.sv
design/psct_ctrl.sv
design/psct_dp.sv
design/per_source_cooldown_table.sv
verif/tb.sv
